FILE: sv/ypsc_pkg.sv
package ypsc_pkg;

    typedef enum logic [2:0] {
        CLS_STRING = 3'd0,
        CLS_NULL   = 3'd1,
        CLS_BOOL   = 3'd2,
        CLS_INT    = 3'd3,
        CLS_FLOAT  = 3'd4
    } t_class;

    typedef enum logic [3:0] {
        N_START = 4'd0,
        N_SIGN  = 4'd1,
        N_ZERO  = 4'd2,
        N_DEC   = 4'd3,
        N_PFX_X = 4'd4,
        N_HEX   = 4'd5,
        N_PFX_O = 4'd6,
        N_OCT   = 4'd7,
        N_DEAD  = 4'd8
    } t_num;

    typedef enum logic [3:0] {
        F_START   = 4'd0,
        F_SIGN    = 4'd1,
        F_INT     = 4'd2,
        F_DOTONLY = 4'd3,
        F_FRAC    = 4'd4,
        F_EXP     = 4'd5,
        F_EXPSIGN = 4'd6,
        F_EXPDIG  = 4'd7,
        F_DEAD    = 4'd8
    } t_flt;

    localparam int KW_COUNT = 16;

    typedef struct packed {
        logic [3:0]          pos;
        logic [KW_COUNT-1:0] kw;
        t_num                num;
        t_flt                flt;
        logic                sgn;
    } t_scan;

    localparam t_scan SCAN_RESET = '{
        pos: 4'd0,
        kw:  16'hFFFF,
        num: N_START,
        flt: F_START,
        sgn: 1'b0
    };

    localparam logic [KW_COUNT-1:0] KW_NULL_MASK = 16'h000F;
    localparam logic [KW_COUNT-1:0] KW_BOOL_MASK = 16'h03F0;
    localparam logic [KW_COUNT-1:0] KW_INF_MASK  = 16'h1C00;
    localparam logic [KW_COUNT-1:0] KW_NAN_MASK  = 16'hE000;

endpackage

FILE: sv/ypsc_step.sv
module ypsc_step
    import ypsc_pkg::*;
(
    input  t_scan       i_scan,
    input  logic [7:0]  i_char,
    input  logic        i_last,
    input  logic        i_empty,
    output t_scan       o_scan,
    output logic        o_res,
    output t_class      o_class
);

    localparam logic [7:0] KW_TEXT [0:KW_COUNT-1][0:5] = '{
        '{"~", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
        '{"n", "u", "l", "l", 8'h00, 8'h00},
        '{"N", "u", "l", "l", 8'h00, 8'h00},
        '{"N", "U", "L", "L", 8'h00, 8'h00},
        '{"t", "r", "u", "e", 8'h00, 8'h00},
        '{"T", "r", "u", "e", 8'h00, 8'h00},
        '{"T", "R", "U", "E", 8'h00, 8'h00},
        '{"f", "a", "l", "s", "e", 8'h00},
        '{"F", "a", "l", "s", "e", 8'h00},
        '{"F", "A", "L", "S", "E", 8'h00},
        '{".", "i", "n", "f", 8'h00, 8'h00},
        '{".", "I", "n", "f", 8'h00, 8'h00},
        '{".", "I", "N", "F", 8'h00, 8'h00},
        '{".", "n", "a", "n", 8'h00, 8'h00},
        '{".", "N", "a", "N", 8'h00, 8'h00},
        '{".", "N", "A", "N", 8'h00, 8'h00}
    };
    localparam logic [3:0] KW_LEN [0:KW_COUNT-1] = '{
        4'd1, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd5,
        4'd5, 4'd5, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4, 4'd4
    };

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic logic is_sgn(input logic [7:0] c);
        return (c == "+") || (c == "-");
    endfunction

    function automatic logic is_hex(input logic [7:0] c);
        return is_dig(c) || ((c >= "a") && (c <= "f")) || ((c >= "A") && (c <= "F"));
    endfunction

    function automatic t_num next_num(input t_num s, input logic [7:0] c);
        t_num n;
        n = N_DEAD;
        unique case (s)
            N_START: begin
                if (is_sgn(c))      n = N_SIGN;
                else if (c == "0")  n = N_ZERO;
                else if (is_dig(c)) n = N_DEC;
            end
            N_SIGN, N_DEC: begin
                if (is_dig(c)) n = N_DEC;
            end
            N_ZERO: begin
                if (is_dig(c))                   n = N_DEC;
                else if (c == "x" || c == "X")   n = N_PFX_X;
                else if (c == "o" || c == "O")   n = N_PFX_O;
            end
            N_PFX_X, N_HEX: begin
                if (is_hex(c)) n = N_HEX;
            end
            N_PFX_O, N_OCT: begin
                if ((c >= "0") && (c <= "7")) n = N_OCT;
            end
            default: n = N_DEAD;
        endcase
        return n;
    endfunction

    function automatic t_flt next_flt(input t_flt s, input logic [7:0] c);
        t_flt n;
        n = F_DEAD;
        unique case (s)
            F_START, F_SIGN: begin
                if (s == F_START && is_sgn(c)) n = F_SIGN;
                else if (is_dig(c))            n = F_INT;
                else if (c == ".")             n = F_DOTONLY;
            end
            F_INT: begin
                if (is_dig(c))                 n = F_INT;
                else if (c == ".")             n = F_FRAC;
                else if (c == "e" || c == "E") n = F_EXP;
            end
            F_DOTONLY: begin
                if (is_dig(c)) n = F_FRAC;
            end
            F_FRAC: begin
                if (is_dig(c))                 n = F_FRAC;
                else if (c == "e" || c == "E") n = F_EXP;
            end
            F_EXP: begin
                if (is_sgn(c))      n = F_EXPSIGN;
                else if (is_dig(c)) n = F_EXPDIG;
            end
            F_EXPSIGN, F_EXPDIG: begin
                if (is_dig(c)) n = F_EXPDIG;
            end
            default: n = F_DEAD;
        endcase
        return n;
    endfunction

    t_scan               w_took;
    logic [3:0]          w_eff;
    logic [3:0]          w_fin_eff;
    logic [KW_COUNT-1:0] w_full;
    t_class              w_cls;

    // per-byte recognizer update
    always_comb begin
        w_took     = i_scan;
        w_eff      = (i_scan.pos >= {3'd0, i_scan.sgn}) ? (i_scan.pos - {3'd0, i_scan.sgn})
                                                        : 4'd0;
        if (i_scan.pos == 4'd0 && is_sgn(i_char)) begin
            w_took.sgn = 1'b1;
            w_took.kw  = i_scan.kw & KW_INF_MASK;
        end else begin
            for (int j = 0; j < KW_COUNT; j++) begin
                if (!((w_eff < KW_LEN[j]) && (KW_TEXT[j][w_eff[2:0]] == i_char)))
                    w_took.kw[j] = 1'b0;
            end
        end
        w_took.num = next_num(i_scan.num, i_char);
        w_took.flt = next_flt(i_scan.flt, i_char);
        if (i_scan.pos != 4'd15)
            w_took.pos = i_scan.pos + 4'd1;
    end

    // class at the final byte
    always_comb begin
        w_fin_eff = (w_took.pos >= {3'd0, w_took.sgn}) ? (w_took.pos - {3'd0, w_took.sgn})
                                                       : 4'd0;
        for (int j = 0; j < KW_COUNT; j++)
            w_full[j] = w_took.kw[j] && (w_fin_eff == KW_LEN[j]);
        priority if (|(w_full & KW_NULL_MASK)) begin
            w_cls = CLS_NULL;
        end else if (|(w_full & KW_BOOL_MASK)) begin
            w_cls = CLS_BOOL;
        end else if (w_took.num == N_ZERO || w_took.num == N_DEC ||
                     w_took.num == N_HEX  || w_took.num == N_OCT) begin
            w_cls = CLS_INT;
        end else if ((|(w_full & (KW_INF_MASK | KW_NAN_MASK))) ||
                     w_took.flt == F_FRAC || w_took.flt == F_EXPDIG) begin
            w_cls = CLS_FLOAT;
        end else begin
            w_cls = CLS_STRING;
        end
    end

    always_comb begin
        if (i_empty) begin
            o_scan  = SCAN_RESET;
            o_res   = 1'b1;
            o_class = CLS_NULL;
        end else if (i_last) begin
            o_scan  = SCAN_RESET;
            o_res   = 1'b1;
            o_class = w_cls;
        end else begin
            o_scan  = w_took;
            o_res   = 1'b0;
            o_class = w_cls;
        end
    end

endmodule

FILE: sv/yaml_plain_scalar_classifier.sv
// channel  | dir | tdata                  | tlast     | tuser
// s_axis   | in  | [7:0] char_code        | last_char | empty_scalar
// m_axis   | out | [2:0] scalar_class     | -         | is_text
//
// One item per cycle on the input side, sustained while m_axis_tready is high.
// Result is valid on m_axis once the last byte has passed through the input
// register, then the recognizer update and classification into the result register.
// Synchronous active-low reset clears the valid flags of both registers and the recognizer state.
// A stall on m_axis holds the result; the input register keeps taking bytes
// that give no result.
module yaml_plain_scalar_classifier
    import ypsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] char_code
    input  logic       s_axis_tlast,
    input  logic       s_axis_tuser,   // [0] empty_scalar
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // [2:0] scalar_class, [7:3] zero
    output logic       m_axis_tuser    // [0] is_text
);

    logic       r_in_valid;
    logic [7:0] r_in_char;
    logic       r_in_last;
    logic       r_in_empty;
    t_scan      r_scan;
    logic       r_out_valid;
    t_class     r_out_class;

    t_scan      n_scan;
    logic       w_res;
    t_class     w_class;
    logic       w_adv;

    ypsc_step u_step (
        .i_scan  (r_scan),
        .i_char  (r_in_char),
        .i_last  (r_in_last),
        .i_empty (r_in_empty),
        .o_scan  (n_scan),
        .o_res   (w_res),
        .o_class (w_class)
    );

    assign w_adv         = r_in_valid && (!w_res || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || w_adv;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_char  <= s_axis_tdata;
            r_in_last  <= s_axis_tlast;
            r_in_empty <= s_axis_tuser;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan <= SCAN_RESET;
        end else if (w_adv) begin
            r_scan <= n_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && w_res) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res) begin
            r_out_class <= w_class;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {5'd0, r_out_class};
    assign m_axis_tuser  = (r_out_class == CLS_STRING);

endmodule

FILE: sv/ypsc_checker.sv
module ypsc_checker
    import ypsc_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       s_axis_tvalid,
    input logic       s_axis_tready,
    input logic [7:0] s_axis_tdata,
    input logic       s_axis_tlast,
    input logic       s_axis_tuser,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // no result right after reset
    a_rst_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // text flag agrees with the class
    a_text_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tuser == (m_axis_tdata[2:0] == CLS_STRING)))
        else $error("is_text disagrees with scalar_class");

    // class code in range, padding zero
    a_class_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:3] == 5'd0 &&
                           (m_axis_tdata[2:0] == CLS_STRING || m_axis_tdata[2:0] == CLS_NULL ||
                            m_axis_tdata[2:0] == CLS_BOOL   || m_axis_tdata[2:0] == CLS_INT  ||
                            m_axis_tdata[2:0] == CLS_FLOAT)))
        else $error("bad scalar_class");

    // stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result changed");

endmodule

bind yaml_plain_scalar_classifier ypsc_checker u_ypsc_checker (.*);

FILE: verif/ypsc_class_checker.sv
`timescale 1ns / 100ps

module ypsc_class_checker
    import ypsc_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_s_tvalid,
    input  logic       i_s_tready,
    input  logic [7:0] i_s_tdata,   // [7:0] char_code
    input  logic       i_s_tlast,
    input  logic       i_s_tuser,   // [0] empty_scalar
    input  logic       i_m_tvalid,
    input  logic       i_m_tready,
    input  logic [7:0] i_m_tdata,   // [2:0] scalar_class, [7:3] zero
    input  logic       i_m_tuser,   // [0] is_text
    output int         o_fail_count,
    output int         o_pending,
    output int         o_checked
);

    // running scan of the scalar in flight
    logic [3:0]          scan_pos;
    logic [KW_COUNT-1:0] kw_live;
    t_num                int_state;
    t_flt                flt_state;
    logic                scan_sign;

    t_class expected_classes[$];

    function automatic string keyword_text(input int j);
        case (j)
            0:       return "~";
            1:       return "null";
            2:       return "Null";
            3:       return "NULL";
            4:       return "true";
            5:       return "True";
            6:       return "TRUE";
            7:       return "false";
            8:       return "False";
            9:       return "FALSE";
            10:      return ".inf";
            11:      return ".Inf";
            12:      return ".INF";
            13:      return ".nan";
            14:      return ".NaN";
            default: return ".NAN";
        endcase
    endfunction

    function automatic logic is_digit(input logic [7:0] c);
        return c >= "0" && c <= "9";
    endfunction

    function automatic logic is_sign(input logic [7:0] c);
        return c == "+" || c == "-";
    endfunction

    function automatic logic is_hexdig(input logic [7:0] c);
        return is_digit(c) || (c >= "a" && c <= "f") || (c >= "A" && c <= "F");
    endfunction

    function automatic t_num next_int(input t_num s, input logic [7:0] c);
        case (s)
            N_START: begin
                if (is_sign(c)) return N_SIGN;
                if (c == "0") return N_ZERO;
                return is_digit(c) ? N_DEC : N_DEAD;
            end
            N_SIGN, N_DEC: return is_digit(c) ? N_DEC : N_DEAD;
            N_ZERO: begin
                if (is_digit(c)) return N_DEC;
                if (c == "x" || c == "X") return N_PFX_X;
                if (c == "o" || c == "O") return N_PFX_O;
                return N_DEAD;
            end
            N_PFX_X, N_HEX: return is_hexdig(c) ? N_HEX : N_DEAD;
            N_PFX_O, N_OCT: return (c >= "0" && c <= "7") ? N_OCT : N_DEAD;
            default: return N_DEAD;
        endcase
    endfunction

    function automatic t_flt next_flt(input t_flt s, input logic [7:0] c);
        case (s)
            F_START, F_SIGN: begin
                if (s == F_START && is_sign(c)) return F_SIGN;
                if (is_digit(c)) return F_INT;
                return (c == ".") ? F_DOTONLY : F_DEAD;
            end
            F_INT: begin
                if (is_digit(c)) return F_INT;
                if (c == ".") return F_FRAC;
                return (c == "e" || c == "E") ? F_EXP : F_DEAD;
            end
            F_DOTONLY: return is_digit(c) ? F_FRAC : F_DEAD;
            F_FRAC: begin
                if (is_digit(c)) return F_FRAC;
                return (c == "e" || c == "E") ? F_EXP : F_DEAD;
            end
            F_EXP: begin
                if (is_sign(c)) return F_EXPSIGN;
                return is_digit(c) ? F_EXPDIG : F_DEAD;
            end
            F_EXPSIGN, F_EXPDIG: return is_digit(c) ? F_EXPDIG : F_DEAD;
            default: return F_DEAD;
        endcase
    endfunction

    task automatic clear_scan();
        scan_pos  = 4'd0;
        kw_live   = '1;
        int_state = N_START;
        flt_state = F_START;
        scan_sign = 1'b0;
    endtask

    task automatic scan_byte(input logic [7:0] c);
        int    eff;
        string w;
        if (scan_pos == 4'd0 && is_sign(c)) begin
            scan_sign = 1'b1;
            kw_live   = kw_live & KW_INF_MASK;
        end else begin
            eff = int'(scan_pos) - int'(scan_sign);
            if (eff < 0) eff = 0;
            for (int j = 0; j < KW_COUNT; j++) begin
                w = keyword_text(j);
                if (kw_live[j] && !(eff < w.len() && w[eff] == c)) kw_live[j] = 1'b0;
            end
        end
        int_state = next_int(int_state, c);
        flt_state = next_flt(flt_state, c);
        if (scan_pos != 4'd15) scan_pos = scan_pos + 4'd1;
    endtask

    function automatic t_class resolve_class();
        logic [KW_COUNT-1:0] full;
        int                  eff;
        string               w;
        eff = int'(scan_pos) - int'(scan_sign);
        if (eff < 0) eff = 0;
        full = '0;
        for (int j = 0; j < KW_COUNT; j++) begin
            w = keyword_text(j);
            if (kw_live[j] && eff == w.len()) full[j] = 1'b1;
        end
        if (|(full & KW_NULL_MASK)) return CLS_NULL;
        if (|(full & KW_BOOL_MASK)) return CLS_BOOL;
        if (int_state == N_ZERO || int_state == N_DEC ||
            int_state == N_HEX || int_state == N_OCT) return CLS_INT;
        if (|(full & (KW_INF_MASK | KW_NAN_MASK)) ||
            flt_state == F_FRAC || flt_state == F_EXPDIG) return CLS_FLOAT;
        return CLS_STRING;
    endfunction

    always @(posedge i_clk) begin
        t_class want;
        if (!i_rst_n) begin
            clear_scan();
            expected_classes.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_classes.size() == 0) begin
                    $error("unexpected result: scalar_class %0d is_text %0b",
                           i_m_tdata[2:0], i_m_tuser);
                    o_fail_count++;
                end else begin
                    want = expected_classes.pop_front();
                    o_checked++;
                    if (i_m_tdata[2:0] !== want) begin
                        $error("scalar_class: expected %0d, got %0d", want, i_m_tdata[2:0]);
                        o_fail_count++;
                    end
                    if (i_m_tuser !== (want == CLS_STRING)) begin
                        $error("is_text: expected %0b, got %0b", want == CLS_STRING, i_m_tuser);
                        o_fail_count++;
                    end
                    if (i_m_tdata[7:3] !== 5'd0) begin
                        $error("tdata pad: expected 0, got %0d", i_m_tdata[7:3]);
                        o_fail_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                if (i_s_tuser) begin
                    clear_scan();
                    expected_classes = {expected_classes, CLS_NULL};
                end else begin
                    scan_byte(i_s_tdata);
                    if (i_s_tlast) begin
                        expected_classes = {expected_classes, resolve_class()};
                        clear_scan();
                    end
                end
            end
        end
        o_pending = expected_classes.size();
    end

endmodule

FILE: verif/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import ypsc_pkg::*;

    logic       i_clk;
    logic       i_rst_n;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;   // [7:0] char_code
    logic       s_axis_tlast;
    logic       s_axis_tuser;   // [0] empty_scalar
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;   // [2:0] scalar_class, [7:3] zero
    logic       m_axis_tuser;   // [0] is_text

    int fail_count;
    int pending;
    int checked;

    logic gaps_on;
    logic stall_on;
    int   n_items;
    int   n_scalars;
    byte  text[$];

    localparam string CHARSET = "0123456789+-.eExXoOnulaNIfFtrs~_ ";

    yaml_plain_scalar_classifier dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    ypsc_class_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_s_tvalid   (s_axis_tvalid),
        .i_s_tready   (s_axis_tready),
        .i_s_tdata    (s_axis_tdata),
        .i_s_tlast    (s_axis_tlast),
        .i_s_tuser    (s_axis_tuser),
        .i_m_tvalid   (m_axis_tvalid),
        .i_m_tready   (m_axis_tready),
        .i_m_tdata    (m_axis_tdata),
        .i_m_tuser    (m_axis_tuser),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !stall_on || ($urandom_range(0, 99) >= 33);
    end

    // called and returns at a falling edge
    task automatic send_item(input logic [7:0] c, input logic last, input logic empty);
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 33) begin
                s_axis_tvalid <= 1'b0;
                @(negedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= c;
        s_axis_tlast  <= last;
        s_axis_tuser  <= empty;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        @(negedge i_clk);
        n_items++;
    endtask

    task automatic send_text();
        if (text.size() == 0) begin
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
        end else begin
            foreach (text[i]) send_item(text[i], i == text.size() - 1, 1'b0);
        end
        n_scalars++;
    endtask

    task automatic put_char(input byte c);
        text = {text, c};
    endtask

    task automatic push_str(input string s);
        for (int i = 0; i < s.len(); i++) put_char(s[i]);
    endtask

    task automatic send_str(input string s);
        text.delete();
        push_str(s);
        send_text();
    endtask

    task automatic push_digits(input int lo, input int hi, input int top_digit);
        int n;
        n = $urandom_range(lo, hi);
        repeat (n) put_char(8'(8'("0") + $urandom_range(0, top_digit)));
    endtask

    task automatic push_sign(input int pct);
        if ($urandom_range(0, 99) < pct) put_char($urandom_range(0, 1) ? "+" : "-");
    endtask

    // well-formed candidates of each class, and a few near misses
    task automatic build_form(input int k);
        string hexdig;
        int    n;
        hexdig = "0123456789abcdefABCDEF";
        case (k)
            0: case ($urandom_range(0, 3))
                0: push_str("~");
                1: push_str("null");
                2: push_str("Null");
                default: push_str("NULL");
            endcase
            1: case ($urandom_range(0, 5))
                0: push_str("true");
                1: push_str("True");
                2: push_str("TRUE");
                3: push_str("false");
                4: push_str("False");
                default: push_str("FALSE");
            endcase
            2: begin
                push_sign(60);
                case ($urandom_range(0, 2))
                    0: push_str(".inf");
                    1: push_str(".Inf");
                    default: push_str(".INF");
                endcase
            end
            3: begin
                push_sign(35);
                case ($urandom_range(0, 2))
                    0: push_str(".nan");
                    1: push_str(".NaN");
                    default: push_str(".NAN");
                endcase
            end
            4: begin
                push_sign(40);
                if ($urandom_range(0, 3) == 0) put_char("0");
                push_digits(1, 6, 9);
            end
            5: begin
                push_sign(10);
                push_str($urandom_range(0, 1) ? "0x" : "0X");
                n = $urandom_range(0, 5);
                repeat (n) put_char(hexdig[$urandom_range(0, hexdig.len() - 1)]);
            end
            6: begin
                push_sign(10);
                push_str($urandom_range(0, 1) ? "0o" : "0O");
                push_digits(0, 5, $urandom_range(0, 3) == 0 ? 9 : 7);
            end
            7, 8: begin
                push_sign(40);
                push_digits(0, 4, 9);
                if ($urandom_range(0, 2) != 0) begin
                    put_char(".");
                    push_digits(0, 3, 9);
                end
                if ($urandom_range(0, 1)) begin
                    put_char($urandom_range(0, 1) ? "e" : "E");
                    push_sign(40);
                    push_digits(0, 3, 9);
                end
            end
            default: begin
                // keyword with case scrambled
                build_form($urandom_range(0, 3));
                foreach (text[i])
                    if ((text[i] | 8'h20) >= "a" && (text[i] | 8'h20) <= "z" &&
                        $urandom_range(0, 2) == 0) text[i] = text[i] ^ 8'h20;
            end
        endcase
    endtask

    task automatic mutate();
        int p;
        p = (text.size() == 0) ? 0 : $urandom_range(0, text.size() - 1);
        case ($urandom_range(0, 3))
            0: if (text.size() != 0) text[p] = CHARSET[$urandom_range(0, CHARSET.len() - 1)];
            1: text.insert(p, CHARSET[$urandom_range(0, CHARSET.len() - 1)]);
            2: if (text.size() > 1) text.delete(p);
            default: put_char(CHARSET[$urandom_range(0, CHARSET.len() - 1)]);
        endcase
    endtask

    task automatic random_scalar();
        int k;
        int n;
        text.delete();
        k = $urandom_range(0, 19);
        if (k <= 9) begin
            build_form(k);
        end else if (k <= 12) begin
            build_form($urandom_range(0, 9));
            mutate();
            if ($urandom_range(0, 2) == 0) mutate();
        end else if (k == 13) begin
            n = $urandom_range(1, 6);
            repeat (n) put_char(8'($urandom_range(0, 255)));
        end else if (k == 14) begin
            n = $urandom_range(1, 8);
            repeat (n) put_char(CHARSET[$urandom_range(0, CHARSET.len() - 1)]);
        end else if (k == 15) begin
            // long numbers; the integer ones are long enough to saturate the position count
            if ($urandom_range(0, 1)) begin
                push_sign(30);
                push_digits(16, 30, 9);
            end else begin
                push_digits(10, 18, 9);
                put_char(".");
                push_digits(1, 8, 9);
            end
        end else if (k == 16) begin
            // empty scalar: text stays empty
        end else if (k == 17) begin
            // partial scalar cut off by an empty flag
            build_form($urandom_range(0, 9));
            foreach (text[i]) send_item(text[i], 1'b0, 1'b0);
            text.delete();
        end else begin
            build_form($urandom_range(0, 9));
        end
        send_text();
    endtask

    task automatic random_until(input int target);
        while (n_items < target) random_scalar();
    endtask

    initial begin
        int guard;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        s_axis_tuser  = 1'b0;
        m_axis_tready = 1'b0;
        gaps_on       = 1'b1;
        stall_on      = 1'b1;
        n_items       = 0;
        n_scalars     = 0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_str("~");
        send_item(8'hFF, 1'b1, 1'b1);   // empty flag wins over last mark
        send_str("-.nan");              // signed nan resolves to string
        send_item("1", 1'b0, 1'b0);
        send_item("2", 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);   // empty flag drops the partial scalar
        send_str("1e5");
        send_str("True");
        send_str("0o7");
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'hFF, 1'b1, 1'b0);

        random_until(700);

        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);

        gaps_on  = 1'b0;
        stall_on = 1'b0;
        random_until(1050);

        gaps_on  = 1'b1;
        stall_on = 1'b1;
        random_until(1650);
        s_axis_tvalid <= 1'b0;

        guard = 0;
        while (pending != 0 && guard < 10000) begin
            @(negedge i_clk);
            guard++;
        end
        repeat (20) @(negedge i_clk);
        if (pending != 0) $error("%0d results never arrived", pending);

        $display("covered %0d bytes in %0d scalars, %0d classifications checked",
                 n_items, n_scalars, checked);
        if (fail_count == 0 && pending == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
